/* rtl/oecp_pkg.sv */
// Shared types, codes and keyword constants for the order event CSV parser.
// No dependencies.
package oecp_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_EVENT  = 3'd1,
    ERR_COUNT  = 3'd2,
    ERR_SIDE   = 3'd3,
    ERR_TYPE   = 3'd4,
    ERR_NUMBER = 3'd5
  } err_t;

  localparam logic [7:0]  CHAR_NL    = 8'd10;
  localparam logic [7:0]  CHAR_COMMA = 8'd44;
  localparam logic [7:0]  CHAR_ZERO  = 8'd48;
  localparam logic [7:0]  CHAR_NINE  = 8'd57;
  localparam logic [47:0] KEY_ADD    = 48'h414444;
  localparam logic [47:0] KEY_CANCEL = 48'h43414E43454C;
  localparam logic [47:0] KEY_MODIFY = 48'h4D4F44494659;
  localparam logic [47:0] KEY_BUY    = 48'h425559;
  localparam logic [47:0] KEY_SELL   = 48'h53454C4C;
  localparam logic [47:0] KEY_LIMIT  = 48'h4C494D4954;
  localparam logic [47:0] KEY_MARKET = 48'h4D41524B4554;
  localparam logic [63:0] MAX_DIV10  = 64'd1844674407370955161;
  localparam int          QUEUE_DEPTH_DEFAULT = 4;

  // One classified byte from the front part.
  typedef struct packed {
    logic       finish;
    logic       comma;
    logic [7:0] text;
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] event_time;
    logic [63:0] ident;
    logic        side;
    logic        otype;
    logic [63:0] price;
    logic [63:0] quantity;
    logic [2:0]  error;
  } rec_t;

endpackage

/* rtl/order_event_csv_parser.sv */
// Top level of the order event CSV parser: front classifier, queue and back parser.
// Depends on oecp_pkg, oecp_front and oecp_back.
// Takes one text byte per cycle while the queue has room; returns one record per nonempty
// line, registered in the cycle after its newline or end-of-stream word leaves the queue.
// Rate is one word per cycle unless output stalls, set by the combinational times-ten
// accumulate in back; the QueueDepth-word front/back queue lets input and output stall apart.
module order_event_csv_parser
  import oecp_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // text_byte
  input  logic         s_axis_tlast,  // end_of_stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [1:0]   m_axis_tuser,  // event_kind
  // event_time[63:0], order_ident[127:64], buy_or_sell[128], limit_or_market[129],
  // order_price[193:130], order_quantity[257:194], error_code[260:258],
  // zero fill to 264
  output logic [263:0] m_axis_tdata
);

  logic q_valid;
  logic q_ready;
  op_t  q_op;
  rec_t rec;

  oecp_front #(.QueueDepth(QueueDepth)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_end(s_axis_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
  );

  oecp_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rec(rec)
  );

  assign m_axis_tuser = rec.kind;
  assign m_axis_tdata = {3'b000, rec.error, rec.quantity, rec.price, rec.otype, rec.side,
                         rec.ident, rec.event_time};

endmodule

/* rtl/oecp_front.sv */
// Front part: accepts stream words and classifies each byte into a queue entry.
// Depends on oecp_pkg.
module oecp_front
  import oecp_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  input  logic in_end,
  output logic q_valid,
  input  logic q_ready,
  output op_t  q_op
);

  localparam int Aw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  op_t mem [QueueDepth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   count;
  logic push;
  logic pop;
  op_t op_in;

  assign in_ready = (count != QueueDepth[Aw:0]);
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_op     = mem[rd_ptr];

  always_comb begin
    op_in.finish = in_end || (in_byte == CHAR_NL);
    op_in.comma  = !op_in.finish && (in_byte == CHAR_COMMA);
    op_in.text   = in_byte;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Aw'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Aw'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (count <= QueueDepth[Aw:0]) else $error("queue count overflow");
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) (count == '0) |-> !pop;
  endproperty
  assert property (p_no_pop_empty) else $error("pop from empty queue");

  property p_count_tracks;
    @(posedge clk) disable iff (rst) (push && !pop && count < QueueDepth[Aw:0])
      |=> count == $past(count) + 1'b1;
  endproperty
  assert property (p_count_tracks) else $error("queue count wrong");

  property p_full_no_push;
    @(posedge clk) disable iff (rst) (count == QueueDepth[Aw:0]) |-> !push;
  endproperty
  assert property (p_full_no_push) else $error("push into full queue");

endmodule

/* rtl/oecp_back.sv */
// Back part: runs the line parser state on each queued byte and registers records.
// Depends on oecp_pkg.
module oecp_back
  import oecp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  op_t  q_op,
  output logic out_valid,
  input  logic out_ready,
  output rec_t out_rec
);

  logic [3:0]  field_number;
  logic [47:0] keyword_buffer;
  logic [2:0]  keyword_length;
  logic [63:0] number_accumulator;
  logic        field_has_chars;
  logic        line_has_chars;
  kind_t       kind_register;
  logic        side_register;
  logic        type_register;
  logic [63:0] value_registers [4];
  err_t        first_error;

  logic take;
  logic emit;
  logic is_num;
  logic [1:0] slot;
  logic is_digit;
  logic [3:0] digit;
  logic ovf;
  logic [63:0] acc_mul;
  kind_t kind_close;
  err_t err_close;
  logic side_close;
  logic type_close;
  logic [3:0] count;
  logic [3:0] expected;
  err_t err_final;
  rec_t rec_next;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;
  assign emit    = take && q_op.finish && line_has_chars;

  // Numeric slot of the current field.
  always_comb begin
    is_num = 1'b0;
    slot   = 2'd0;
    if (kind_register != KIND_BAD) begin
      unique case (field_number)
        4'd1: begin is_num = 1'b1; slot = 2'd0; end
        4'd2: begin is_num = 1'b1; slot = 2'd1; end
        4'd3: begin
          is_num = (kind_register == KIND_MODIFY); slot = 2'd2;
        end
        4'd4: begin
          is_num = (kind_register == KIND_MODIFY); slot = 2'd3;
        end
        4'd5: begin is_num = (kind_register == KIND_ADD); slot = 2'd2; end
        4'd6: begin is_num = (kind_register == KIND_ADD); slot = 2'd3; end
        default: begin is_num = 1'b0; slot = 2'd0; end
      endcase
    end
  end

  assign is_digit = (q_op.text >= CHAR_ZERO) && (q_op.text <= CHAR_NINE);
  assign digit    = 4'(q_op.text - CHAR_ZERO);
  assign acc_mul  = (number_accumulator << 3) + (number_accumulator << 1);
  assign ovf = (number_accumulator > MAX_DIV10) ||
               ((number_accumulator == MAX_DIV10) && (digit > 4'd5));

  // Closing the current field.
  always_comb begin
    kind_close = kind_register;
    side_close = side_register;
    type_close = type_register;
    err_close  = first_error;
    if (field_number == 4'd0) begin
      if (keyword_length == 3'd3 && keyword_buffer == KEY_ADD) begin
        kind_close = KIND_ADD;
      end else if (keyword_length == 3'd6 && keyword_buffer == KEY_CANCEL) begin
        kind_close = KIND_CANCEL;
      end else if (keyword_length == 3'd6 && keyword_buffer == KEY_MODIFY) begin
        kind_close = KIND_MODIFY;
      end else begin
        kind_close = KIND_BAD;
        if (first_error == ERR_OK) err_close = ERR_EVENT;
      end
    end else if (is_num) begin
      if (!field_has_chars && first_error == ERR_OK) err_close = ERR_NUMBER;
    end else if (kind_register == KIND_ADD && field_number == 4'd3) begin
      if (keyword_length == 3'd3 && keyword_buffer == KEY_BUY) begin
        side_close = 1'b0;
      end else if (keyword_length == 3'd4 && keyword_buffer == KEY_SELL) begin
        side_close = 1'b1;
      end else if (first_error == ERR_OK) begin
        err_close = ERR_SIDE;
      end
    end else if (kind_register == KIND_ADD && field_number == 4'd4) begin
      if (keyword_length == 3'd5 && keyword_buffer == KEY_LIMIT) begin
        type_close = 1'b0;
      end else if (keyword_length == 3'd6 && keyword_buffer == KEY_MARKET) begin
        type_close = 1'b1;
      end else if (first_error == ERR_OK) begin
        err_close = ERR_TYPE;
      end
    end
  end

  // Record assembly at end of line.
  always_comb begin
    kind_t k;
    err_t  fe;
    logic  sd;
    logic  ty;
    logic [63:0] v [4];
    k  = field_has_chars ? kind_close : kind_register;
    fe = field_has_chars ? err_close : first_error;
    sd = field_has_chars ? side_close : side_register;
    ty = field_has_chars ? type_close : type_register;
    for (int i = 0; i < 4; i++) begin
      v[i] = value_registers[i];
    end
    if (field_has_chars && is_num) begin
      v[slot] = number_accumulator;
    end
    count = field_has_chars ? field_number + 4'd1 : field_number;
    unique case (k)
      KIND_ADD:    expected = 4'd7;
      KIND_CANCEL: expected = 4'd3;
      default:     expected = 4'd5;
    endcase
    if (fe == ERR_EVENT) begin
      err_final = ERR_EVENT;
    end else if (count != expected) begin
      err_final = ERR_COUNT;
    end else begin
      err_final = fe;
    end
    rec_next = '0;
    rec_next.error = err_final;
    if (err_final == ERR_OK) begin
      rec_next.kind       = k;
      rec_next.event_time = v[0];
      rec_next.ident      = v[1];
      if (k == KIND_ADD) begin
        rec_next.side  = sd;
        rec_next.otype = ty;
      end
      if (k != KIND_CANCEL) begin
        rec_next.price    = v[2];
        rec_next.quantity = v[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rec <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number       <= '0;
      keyword_buffer     <= '0;
      keyword_length     <= '0;
      number_accumulator <= '0;
      field_has_chars    <= 1'b0;
      line_has_chars     <= 1'b0;
      kind_register      <= KIND_ADD;
      side_register      <= 1'b0;
      type_register      <= 1'b0;
      first_error        <= ERR_OK;
      for (int i = 0; i < 4; i++) value_registers[i] <= '0;
    end else if (take) begin
      if (q_op.finish) begin
        if (line_has_chars) begin
          field_number       <= '0;
          keyword_buffer     <= '0;
          keyword_length     <= '0;
          number_accumulator <= '0;
          field_has_chars    <= 1'b0;
          line_has_chars     <= 1'b0;
          kind_register      <= KIND_ADD;
          side_register      <= 1'b0;
          type_register      <= 1'b0;
          first_error        <= ERR_OK;
          for (int i = 0; i < 4; i++) value_registers[i] <= '0;
        end
      end else if (q_op.comma) begin
        line_has_chars     <= 1'b1;
        kind_register      <= kind_close;
        side_register      <= side_close;
        type_register      <= type_close;
        first_error        <= err_close;
        if (is_num) value_registers[slot] <= number_accumulator;
        keyword_buffer     <= '0;
        keyword_length     <= '0;
        number_accumulator <= '0;
        field_has_chars    <= 1'b0;
        if (field_number != 4'd15) field_number <= field_number + 4'd1;
      end else begin
        line_has_chars  <= 1'b1;
        field_has_chars <= 1'b1;
        if (keyword_length < 3'd6) begin
          keyword_buffer <= {keyword_buffer[39:0], q_op.text};
          keyword_length <= keyword_length + 3'd1;
        end else begin
          keyword_length <= 3'd7;
        end
        if (is_num) begin
          if (is_digit && !ovf) begin
            number_accumulator <= acc_mul + {60'd0, digit};
          end else if (first_error == ERR_OK) begin
            first_error <= ERR_NUMBER;
          end
        end
      end
    end
  end

  property p_emit_sets_valid;
    @(posedge clk) disable iff (rst) emit |=> out_valid;
  endproperty
  assert property (p_emit_sets_valid) else $error("record lost");

  property p_hold_when_stalled;
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |-> !take;
  endproperty
  assert property (p_hold_when_stalled) else $error("byte taken while record stalled");

  property p_error_clears_fields;
    @(posedge clk) disable iff (rst)
      (out_valid && out_rec.error != ERR_OK) |-> (out_rec.event_time == '0 &&
       out_rec.kind == KIND_ADD && out_rec.price == '0);
  endproperty
  assert property (p_error_clears_fields) else $error("error record carries data");

endmodule
